### rtl/tct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_pkg
// Shared constants, codes and controller/datapath handshake types for the
// touch contact tracker.
// ----------------------------------------------------------------------------
package tct_pkg;

   localparam int MAX_CONTACTS = 10;
   localparam int IDX_W        = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;

   localparam logic [23:0] TPM_RESET = 24'd10000;

   // quotient bits produced by the serial divider (speed magnitude < 2^24)
   localparam int DIV_STEPS = 24;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [1:0] OP_POINT     = 2'd0;
   localparam logic [1:0] OP_FRAME     = 2'd1;
   localparam logic [1:0] OP_FRAME_SYN = 2'd2;

   localparam logic [1:0] PS_PRESSED  = 2'd0;
   localparam logic [1:0] PS_MOVED    = 2'd1;
   localparam logic [1:0] PS_RELEASED = 2'd2;

   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_UPDATE = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   typedef struct packed {
      logic       capture;
      logic       mark_seen;
      logic       clear_seen;
      logic       sweep_init;
      logic       sweep_adv;
      logic       start;
      logic       prep;
      logic       mul;
      logic       div_step;
      logic       update;
      logic       emit;
      logic [1:0] kind;
      logic       last;
      logic       use_frame;
      logic       clear_valid;
      logic       clear_mask;
   } tct_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       id_ok;
      logic [1:0] ps;
      logic       act;
      logic       slot_valid;
      logic       vel_ok;
      logic       div_done;
      logic       out_free;
      logic       sweep_hit;
      logic       mask_empty;
      logic       mask_last;
   } tct_status_type;

endpackage

### rtl/tct_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_ifs
// Channel interfaces: touch input words, event words and register writes.
// ----------------------------------------------------------------------------
interface tct_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [7:0]  contact_id;
   logic [1:0]  point_state;
   logic        active_flag;
   logic [15:0] pos_x;
   logic [15:0] pos_y;
   logic [47:0] stamp;

   modport source (output valid, opcode, contact_id, point_state, active_flag,
                   pos_x, pos_y, stamp, input ready);
   modport sink   (input valid, opcode, contact_id, point_state, active_flag,
                   pos_x, pos_y, stamp, output ready);
endinterface

interface tct_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         event_kind;
   logic [7:0]         event_id;
   logic [15:0]        origin_x;
   logic [15:0]        origin_y;
   logic [15:0]        now_x;
   logic [15:0]        now_y;
   logic signed [24:0] speed_x;
   logic signed [24:0] speed_y;
   logic [47:0]        first_stamp;
   logic [47:0]        latest_stamp;
   logic [31:0]        frames_seen;
   logic               last;

   modport source (output valid, event_kind, event_id, origin_x, origin_y, now_x,
                   now_y, speed_x, speed_y, first_stamp, latest_stamp,
                   frames_seen, last, input ready);
   modport sink   (input valid, event_kind, event_id, origin_x, origin_y, now_x,
                   now_y, speed_x, speed_y, first_stamp, latest_stamp,
                   frames_seen, last, output ready);
endinterface

interface tct_csr_if;
   logic        valid;
   logic        ready;
   logic [23:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### rtl/tct_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_ctrl
// Sequencer: decodes each word and steps the datapath through start,
// update, divide, sweep and emit phases.
// ----------------------------------------------------------------------------
module tct_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tct_pkg::tct_status_type sts,
   output tct_pkg::tct_cmd_type    cmd
);

   typedef enum logic [10:0] {
      S_IDLE       = 11'b00000000001,
      S_DISPATCH   = 11'b00000000010,
      S_EMIT_STALE = 11'b00000000100,
      S_START      = 11'b00000001000,
      S_EMIT_NEW   = 11'b00000010000,
      S_PREP       = 11'b00000100000,
      S_MUL        = 11'b00001000000,
      S_DIV        = 11'b00010000000,
      S_UPDATE     = 11'b00100000000,
      S_EMIT_UPD   = 11'b01000000000,
      S_SWEEP      = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_IDLE;
            if (sts.op == tct_pkg::OP_POINT) begin
               if (sts.id_ok) begin
                  cmd.mark_seen = sts.act || sts.ps == tct_pkg::PS_PRESSED ||
                                  sts.ps == tct_pkg::PS_MOVED;
                  case (sts.ps)
                     tct_pkg::PS_PRESSED:
                        state_in = sts.slot_valid ? S_EMIT_STALE : S_START;
                     tct_pkg::PS_MOVED:
                        state_in = sts.slot_valid ? S_PREP : S_START;
                     tct_pkg::PS_RELEASED:
                        state_in = sts.slot_valid ? S_PREP : S_IDLE;
                     default: state_in = S_IDLE;
                  endcase
               end
            end else if (sts.op == tct_pkg::OP_FRAME) begin
               cmd.clear_seen = 1'b1;
            end else if (sts.op == tct_pkg::OP_FRAME_SYN) begin
               cmd.sweep_init = 1'b1;
               state_in       = S_SWEEP;
            end
         end
         S_EMIT_STALE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = tct_pkg::KIND_END;
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.start = 1'b1;
            state_in  = S_EMIT_NEW;
         end
         S_EMIT_NEW: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = tct_pkg::KIND_START;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = sts.vel_ok ? S_DIV : S_UPDATE;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_EMIT_UPD;
         end
         S_EMIT_UPD: begin
            if (sts.out_free) begin
               cmd.emit        = 1'b1;
               cmd.last        = 1'b1;
               cmd.clear_valid = (sts.ps == tct_pkg::PS_RELEASED);
               cmd.kind        = (sts.ps == tct_pkg::PS_RELEASED) ?
                                 tct_pkg::KIND_END : tct_pkg::KIND_UPDATE;
               state_in        = S_IDLE;
            end
         end
         S_SWEEP: begin
            if (sts.mask_empty) begin
               cmd.clear_seen = 1'b1;
               state_in       = S_IDLE;
            end else if (sts.sweep_hit) begin
               if (sts.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.kind        = tct_pkg::KIND_END;
                  cmd.use_frame   = 1'b1;
                  cmd.last        = sts.mask_last;
                  cmd.clear_valid = 1'b1;
                  cmd.clear_mask  = 1'b1;
                  cmd.sweep_adv   = 1'b1;
               end
            end else begin
               cmd.sweep_adv = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

### rtl/tct_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_datapath
// Contact table, velocity multiplier and serial dividers, and the event
// output register.
// ----------------------------------------------------------------------------
module tct_datapath (
   input  logic                    clock,
   input  logic                    reset,
   tct_req_if.sink                 req_ch,
   tct_rsp_if.source               rsp_ch,
   input  logic [23:0]             tpm,
   input  tct_pkg::tct_cmd_type    cmd,
   output tct_pkg::tct_status_type sts
);

   localparam int N = tct_pkg::MAX_CONTACTS;
   localparam int W = tct_pkg::IDX_W;

   // captured input word
   logic [1:0]  op_ff;
   logic        id_ok_ff;
   logic [1:0]  ps_ff;
   logic        act_ff;
   logic [15:0] x_ff, y_ff;
   logic [47:0] stamp_ff;
   logic [W-1:0] idx_ff;

   // contact table
   logic [N-1:0] valid_ff, seen_ff, mask_ff;
   logic [31:0]  start_xy_ff [N];
   logic [31:0]  cur_xy_ff   [N];
   logic [47:0]  first_ff    [N];
   logic [47:0]  latest_ff   [N];
   logic [24:0]  vel_x_ff    [N];
   logic [24:0]  vel_y_ff    [N];
   logic [31:0]  frames_ff   [N];

   // velocity arithmetic
   logic [47:0] delta_ff;
   logic        vel_ok_ff;
   logic        neg_x_ff, neg_y_ff;
   logic [15:0] abs_x_ff, abs_y_ff;
   logic [47:0] rem_x_ff, rem_y_ff;
   logic [23:0] lo_x_ff, lo_y_ff;
   logic [23:0] q_x_ff, q_y_ff;
   logic [tct_pkg::CNT_W-1:0] cnt_ff;

   logic        rsp_valid_ff;

   logic [48:0] diff;
   logic [16:0] dx, dy;
   logic [39:0] prod_x, prod_y;
   logic [48:0] tx, ty;
   logic        gx, gy;
   logic [N-1:0] idx_bit;
   logic [23:0] tpm_eff;

   assign tpm_eff = (tpm == 24'd0) ? 24'd1 : tpm;
   assign idx_bit = N'(1) << idx_ff;

   assign diff = {1'b0, stamp_ff} - {1'b0, latest_ff[idx_ff]};
   assign dx   = {1'b0, x_ff} - {1'b0, cur_xy_ff[idx_ff][15:0]};
   assign dy   = {1'b0, y_ff} - {1'b0, cur_xy_ff[idx_ff][31:16]};

   assign prod_x = abs_x_ff * tpm_eff;
   assign prod_y = abs_y_ff * tpm_eff;

   assign tx = {rem_x_ff, lo_x_ff[23]};
   assign ty = {rem_y_ff, lo_y_ff[23]};
   assign gx = (tx >= {1'b0, delta_ff});
   assign gy = (ty >= {1'b0, delta_ff});

   always_comb begin
      sts            = '0;
      sts.op         = op_ff;
      sts.id_ok      = id_ok_ff;
      sts.ps         = ps_ff;
      sts.act        = act_ff;
      sts.slot_valid = valid_ff[idx_ff];
      sts.vel_ok     = vel_ok_ff;
      sts.div_done   = (cnt_ff == tct_pkg::CNT_W'(tct_pkg::DIV_STEPS - 1));
      sts.out_free   = !rsp_valid_ff || rsp_ch.ready;
      sts.sweep_hit  = mask_ff[idx_ff];
      sts.mask_empty = (mask_ff == '0);
      sts.mask_last  = ((mask_ff & ~idx_bit) == '0);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         seen_ff      <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.mark_seen) begin
            seen_ff <= seen_ff | idx_bit;
         end
         if (cmd.clear_seen) begin
            seen_ff <= '0;
         end
         if (cmd.sweep_init) begin
            mask_ff <= valid_ff & ~seen_ff;
         end else if (cmd.clear_mask) begin
            mask_ff <= mask_ff & ~idx_bit;
         end
         if (cmd.start) begin
            valid_ff <= valid_ff | idx_bit;
         end else if (cmd.clear_valid) begin
            valid_ff <= valid_ff & ~idx_bit;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_ch.opcode;
         id_ok_ff <= (req_ch.contact_id < 8'(N));
         ps_ff    <= req_ch.point_state;
         act_ff   <= req_ch.active_flag;
         x_ff     <= req_ch.pos_x;
         y_ff     <= req_ch.pos_y;
         stamp_ff <= req_ch.stamp;
         idx_ff   <= req_ch.contact_id[W-1:0];
      end else if (cmd.sweep_init) begin
         idx_ff <= '0;
      end else if (cmd.sweep_adv) begin
         idx_ff <= idx_ff + W'(1);
      end

      if (cmd.prep) begin
         delta_ff  <= diff[47:0];
         vel_ok_ff <= !diff[48] && (diff[47:0] >= {24'd0, tpm_eff});
         neg_x_ff  <= dx[16];
         neg_y_ff  <= dy[16];
         abs_x_ff  <= dx[16] ? 16'(-dx) : dx[15:0];
         abs_y_ff  <= dy[16] ? 16'(-dy) : dy[15:0];
      end

      // numerator = |d| * tpm * 256; upper half seeds the remainder
      if (cmd.mul) begin
         rem_x_ff <= {24'd0, prod_x[39:16]};
         rem_y_ff <= {24'd0, prod_y[39:16]};
         lo_x_ff  <= {prod_x[15:0], 8'd0};
         lo_y_ff  <= {prod_y[15:0], 8'd0};
         cnt_ff   <= '0;
      end else if (cmd.div_step) begin
         rem_x_ff <= gx ? 48'(tx - {1'b0, delta_ff}) : tx[47:0];
         rem_y_ff <= gy ? 48'(ty - {1'b0, delta_ff}) : ty[47:0];
         lo_x_ff  <= {lo_x_ff[22:0], 1'b0};
         lo_y_ff  <= {lo_y_ff[22:0], 1'b0};
         q_x_ff   <= {q_x_ff[22:0], gx};
         q_y_ff   <= {q_y_ff[22:0], gy};
         cnt_ff   <= cnt_ff + tct_pkg::CNT_W'(1);
      end

      if (cmd.start) begin
         start_xy_ff[idx_ff] <= {y_ff, x_ff};
         cur_xy_ff[idx_ff]   <= {y_ff, x_ff};
         first_ff[idx_ff]    <= stamp_ff;
         latest_ff[idx_ff]   <= stamp_ff;
         vel_x_ff[idx_ff]    <= '0;
         vel_y_ff[idx_ff]    <= '0;
         frames_ff[idx_ff]   <= 32'd1;
      end else if (cmd.update) begin
         cur_xy_ff[idx_ff] <= {y_ff, x_ff};
         latest_ff[idx_ff] <= stamp_ff;
         if (frames_ff[idx_ff] != '1) begin
            frames_ff[idx_ff] <= frames_ff[idx_ff] + 32'd1;
         end
         if (vel_ok_ff) begin
            vel_x_ff[idx_ff] <= neg_x_ff ? 25'(-{1'b0, q_x_ff}) : {1'b0, q_x_ff};
            vel_y_ff[idx_ff] <= neg_y_ff ? 25'(-{1'b0, q_y_ff}) : {1'b0, q_y_ff};
         end
      end

      if (cmd.emit) begin
         rsp_ch.event_kind   <= cmd.kind;
         rsp_ch.event_id     <= 8'(idx_ff);
         rsp_ch.origin_x     <= start_xy_ff[idx_ff][15:0];
         rsp_ch.origin_y     <= start_xy_ff[idx_ff][31:16];
         rsp_ch.now_x        <= cur_xy_ff[idx_ff][15:0];
         rsp_ch.now_y        <= cur_xy_ff[idx_ff][31:16];
         rsp_ch.speed_x      <= vel_x_ff[idx_ff];
         rsp_ch.speed_y      <= vel_y_ff[idx_ff];
         rsp_ch.first_stamp  <= first_ff[idx_ff];
         rsp_ch.latest_stamp <= cmd.use_frame ? stamp_ff : latest_ff[idx_ff];
         rsp_ch.frames_seen  <= frames_ff[idx_ff];
         rsp_ch.last         <= cmd.last;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;

endmodule

### rtl/touch_contact_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_contact_tracker
// Per-id touch contact table producing start, update and end event words.
// ----------------------------------------------------------------------------
// Flow: a start event follows dispatch and the start step, after an end event
// for a stale contact; an update runs prep, multiply, the 24-step serial
// divider when the velocity is recomputed, update and emit; a sync frame end
// sweeps one slot per cycle (up to MAX_CONTACTS) unless an end event waits.
// The next word is taken while the last event sits in the output register.
// Reset: synchronous, clears all contact and seen marks; ticks_per_ms = 10000.
// ----------------------------------------------------------------------------
module touch_contact_tracker (
   input  logic       clock,
   input  logic       reset,
   tct_req_if.sink    req_ch,
   tct_rsp_if.source  rsp_ch,
   tct_csr_if.sink    csr_ch
);

   tct_pkg::tct_cmd_type    cmd;
   tct_pkg::tct_status_type sts;

   // ticks per millisecond; zero is treated as one inside the datapath
   logic [23:0] tpm_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tpm_ff <= tct_pkg::TPM_RESET;
      end else if (csr_ch.valid) begin
         tpm_ff <= csr_ch.data;
      end
   end

   // sequencer: holds input ready only while idle
   tct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table, velocity math and the output word register
   tct_datapath u_dp (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .tpm    (tpm_ff),
      .cmd    (cmd),
      .sts    (sts)
   );

endmodule

### rtl/tct_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_checker
// Port-level checks on the event channel of the contact tracker.
// ----------------------------------------------------------------------------
module tct_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  event_kind,
   input logic [7:0]  event_id,
   input logic [31:0] frames_seen
);

   // a pending word stays until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("event word dropped before accept");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> event_kind != 2'd3)
      else $error("bad event kind");

   a_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> event_id < 8'(tct_pkg::MAX_CONTACTS))
      else $error("event id outside table");

   a_frames: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> frames_seen != 32'd0)
      else $error("contact with zero points");

endmodule

bind touch_contact_tracker tct_checker u_chk (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .event_kind  (rsp_ch.event_kind),
   .event_id    (rsp_ch.event_id),
   .frames_seen (rsp_ch.frames_seen)
);

### tb/tb_touch_contact_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_contact_tracker
// Self-checking bench for the touch contact tracker: drives point and frame
// words with random bursts, predicts every event word from its own contact
// table and compares each event field by field, under random output stalls.
// ----------------------------------------------------------------------------
module tb_touch_contact_tracker;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         id;
      logic [15:0]        ox;
      logic [15:0]        oy;
      logic [15:0]        nx;
      logic [15:0]        ny;
      logic signed [24:0] vx;
      logic signed [24:0] vy;
      logic [47:0]        t0;
      logic [47:0]        t1;
      logic [31:0]        frames;
      logic               last;
   } touch_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tct_req_if req_ch ();
   tct_rsp_if rsp_ch ();
   tct_csr_if csr_ch ();

   touch_contact_tracker dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the contact table
   logic [23:0]        tick_rate;
   logic               live    [tct_pkg::MAX_CONTACTS];
   logic               seen    [tct_pkg::MAX_CONTACTS];
   logic [15:0]        org_x   [tct_pkg::MAX_CONTACTS];
   logic [15:0]        org_y   [tct_pkg::MAX_CONTACTS];
   logic [15:0]        cur_x   [tct_pkg::MAX_CONTACTS];
   logic [15:0]        cur_y   [tct_pkg::MAX_CONTACTS];
   logic [47:0]        born_at [tct_pkg::MAX_CONTACTS];
   logic [47:0]        last_at [tct_pkg::MAX_CONTACTS];
   logic signed [24:0] vel_x   [tct_pkg::MAX_CONTACTS];
   logic signed [24:0] vel_y   [tct_pkg::MAX_CONTACTS];
   logic [31:0]        hits    [tct_pkg::MAX_CONTACTS];

   touch_event_type pending_events[$];
   int           failures   = 0;
   int           cycle_cnt  = 0;
   int           hold_off   = 0;   // long receiver stall, counted down
   bit           random_gaps = 1'b1;

   localparam int CYCLE_LIMIT = 400000;

   // ---- predictor ---------------------------------------------------------
   function automatic void push_event(logic [1:0] kind, int i, logic [47:0] t);
      touch_event_type e;
      e.kind = kind;  e.id = i[7:0];
      e.ox = org_x[i]; e.oy = org_y[i]; e.nx = cur_x[i]; e.ny = cur_y[i];
      e.vx = vel_x[i]; e.vy = vel_y[i];
      e.t0 = born_at[i]; e.t1 = t; e.frames = hits[i]; e.last = 1'b0;
      pending_events = {pending_events, e};
   endfunction

   function automatic void open_contact(int i, logic [15:0] x, logic [15:0] y,
                                        logic [47:0] t);
      live[i] = 1'b1;
      org_x[i] = x; org_y[i] = y; cur_x[i] = x; cur_y[i] = y;
      born_at[i] = t; last_at[i] = t;
      vel_x[i] = '0; vel_y[i] = '0; hits[i] = 32'd1;
   endfunction

   function automatic void move_contact(int i, logic [15:0] x, logic [15:0] y,
                                        logic [47:0] t);
      longint tpm, delta, dx, dy;
      tpm   = (tick_rate == 0) ? 64'sd1 : longint'(tick_rate);
      delta = longint'({16'd0, t}) - longint'({16'd0, last_at[i]});
      if (delta >= tpm) begin
         dx = longint'(x) - longint'(cur_x[i]);
         dy = longint'(y) - longint'(cur_y[i]);
         vel_x[i] = 25'((dx * 256 * tpm) / delta);
         vel_y[i] = 25'((dy * 256 * tpm) / delta);
      end
      cur_x[i] = x; cur_y[i] = y; last_at[i] = t;
      if (hits[i] != 32'hFFFF_FFFF) hits[i]++;
   endfunction

   function automatic void predict_events(logic [1:0] op, logic [7:0] id,
         logic [1:0] ps, logic act, logic [15:0] x, logic [15:0] y,
         logic [47:0] t);
      int n0;
      n0 = pending_events.size();
      if (op == tct_pkg::OP_POINT) begin
         if (id < tct_pkg::MAX_CONTACTS) begin
            if (act || ps == tct_pkg::PS_PRESSED || ps == tct_pkg::PS_MOVED)
               seen[id] = 1'b1;
            if (ps == tct_pkg::PS_PRESSED) begin
               if (live[id]) push_event(tct_pkg::KIND_END, id, last_at[id]);
               open_contact(id, x, y, t);
               push_event(tct_pkg::KIND_START, id, t);
            end else if (ps == tct_pkg::PS_MOVED) begin
               if (live[id]) begin
                  move_contact(id, x, y, t);
                  push_event(tct_pkg::KIND_UPDATE, id, t);
               end else begin
                  open_contact(id, x, y, t);
                  push_event(tct_pkg::KIND_START, id, t);
               end
            end else if (ps == tct_pkg::PS_RELEASED && live[id]) begin
               move_contact(id, x, y, t);
               push_event(tct_pkg::KIND_END, id, t);
               live[id] = 1'b0;
            end
         end
      end else if (op == tct_pkg::OP_FRAME || op == tct_pkg::OP_FRAME_SYN) begin
         if (op == tct_pkg::OP_FRAME_SYN)
            for (int i = 0; i < tct_pkg::MAX_CONTACTS; i++)
               if (live[i] && !seen[i]) begin
                  push_event(tct_pkg::KIND_END, i, t);
                  live[i] = 1'b0;
               end
         for (int i = 0; i < tct_pkg::MAX_CONTACTS; i++) seen[i] = 1'b0;
      end
      if (pending_events.size() > n0)
         pending_events[pending_events.size() - 1].last = 1'b1;
   endfunction

   // ---- drivers -----------------------------------------------------------
   // Send one word; hold it until taken, then predict its events.
   task automatic send_word(logic [1:0] op, logic [7:0] id, logic [1:0] ps,
         logic act, logic [15:0] x, logic [15:0] y, logic [47:0] t);
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op; req_ch.contact_id <= id; req_ch.point_state <= ps;
      req_ch.active_flag <= act; req_ch.pos_x <= x; req_ch.pos_y <= y;
      req_ch.stamp <= t;
      do @(posedge clock); while (!req_ch.ready);
      predict_events(op, id, ps, act, x, y, t);
      @(negedge clock);
      // drop valid only when a gap follows; back-to-back keeps it high
      if (random_gaps && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic idle_sender();
      req_ch.valid <= 1'b0;
   endtask

   task automatic drain();
      idle_sender();
      while (pending_events.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);  // let a silent word finish its work
   endtask

   task automatic write_rate(logic [23:0] v);
      drain();
      csr_ch.valid <= 1'b1; csr_ch.data <= v;
      do @(posedge clock); while (!csr_ch.ready);
      tick_rate = v;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // ---- checker -----------------------------------------------------------
   always @(posedge clock) begin
      touch_event_type a, e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         a = {rsp_ch.event_kind, rsp_ch.event_id, rsp_ch.origin_x, rsp_ch.origin_y,
              rsp_ch.now_x, rsp_ch.now_y, rsp_ch.speed_x, rsp_ch.speed_y,
              rsp_ch.first_stamp, rsp_ch.latest_stamp, rsp_ch.frames_seen,
              rsp_ch.last};
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected event word %p", $time, a);
            failures++;
         end else begin
            e = pending_events.pop_front();
            if (a.kind !== e.kind || a.id !== e.id || a.ox !== e.ox ||
                a.oy !== e.oy || a.nx !== e.nx || a.ny !== e.ny ||
                a.vx !== e.vx || a.vy !== e.vy || a.t0 !== e.t0 ||
                a.t1 !== e.t1 || a.frames !== e.frames || a.last !== e.last) begin
               $display("%0t: event mismatch expected %p actual %p", $time, e, a);
               failures++;
            end
         end
      end
   end

   // receiver stalls: a pattern of its own plus a counted long hold-off
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ch.ready <= 1'b0;
      end else if (cycle_cnt[9:8] == 2'b11)
         rsp_ch.ready <= 1'b1;          // stretch with no stalls
      else
         rsp_ch.ready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---- tests -------------------------------------------------------------
   logic [47:0] clk_now = 48'd1000;

   function automatic logic [47:0] rand_xy_time(int lo, int hi);
      clk_now = clk_now + 48'($urandom_range(lo, hi));
      return clk_now;
   endfunction

   task automatic test_directed();
      logic [47:0] t;
      send_word(tct_pkg::OP_POINT, 8'd0, tct_pkg::PS_PRESSED, 1'b1, 16'd0, 16'd0,
                48'd1000);
      send_word(tct_pkg::OP_POINT, 8'd0, tct_pkg::PS_MOVED, 1'b1, 16'hFFFF, 16'hFFFF,
                48'd21000);
      send_word(tct_pkg::OP_POINT, 8'd0, tct_pkg::PS_MOVED, 1'b0, 16'd0, 16'd0,
                48'd25000); // < 1 ms
      send_word(tct_pkg::OP_POINT, 8'd0, tct_pkg::PS_MOVED, 1'b0, 16'd0, 16'hFFFF,
                48'd35000);
      send_word(tct_pkg::OP_POINT, 8'd0, tct_pkg::PS_PRESSED, 1'b1, 16'd5, 16'd6,
                48'd36000); // stale
      send_word(tct_pkg::OP_POINT, 8'd9, tct_pkg::PS_MOVED, 1'b1, 16'd7, 16'd8,
                48'd36000); // empty
      send_word(tct_pkg::OP_POINT, 8'd9, 2'd3, 1'b1, 16'd1, 16'd1, 48'd37000); // other
      send_word(tct_pkg::OP_POINT, 8'd9, tct_pkg::PS_RELEASED, 1'b0, 16'd100, 16'd3,
                48'd60000);
      send_word(tct_pkg::OP_POINT, 8'd9, tct_pkg::PS_RELEASED, 1'b1, 16'd1, 16'd1,
                48'd61000);
      send_word(tct_pkg::OP_POINT, 8'd10, tct_pkg::PS_PRESSED, 1'b1, 16'd1, 16'd1,
                48'd61000);
      send_word(tct_pkg::OP_POINT, 8'd255, tct_pkg::PS_MOVED, 1'b1, 16'd1, 16'd1,
                48'd61000);
      send_word(2'd3, 8'd0, tct_pkg::PS_PRESSED, 1'b1, 16'd1, 16'd1, 48'd61000);
      send_word(tct_pkg::OP_POINT, 8'd3, tct_pkg::PS_PRESSED, 1'b1, 16'd2, 16'd2,
                48'd62000);
      send_word(tct_pkg::OP_FRAME, 8'd0, 2'd0, 1'b0, 16'd0, 16'd0, 48'd63000);
      send_word(tct_pkg::OP_FRAME_SYN, 8'd0, 2'd0, 1'b0, 16'd0, 16'd0,
                48'hFFFF_FFFF_FFFF);
      send_word(tct_pkg::OP_POINT, 8'd1, tct_pkg::PS_PRESSED, 1'b0, 16'd9, 16'd9,
                48'hFFFF_FFFF_FFF0);
      send_word(tct_pkg::OP_POINT, 8'd1, tct_pkg::PS_MOVED, 1'b0, 16'd0, 16'd9,
                48'd0); // time back
      t = 48'd0;
      send_word(tct_pkg::OP_FRAME_SYN, 8'd0, 2'd0, 1'b0, 16'd0, 16'd0, t);
      send_word(tct_pkg::OP_FRAME_SYN, 8'd0, 2'd0, 1'b0, 16'd0, 16'd0, 48'd5);
   endtask

   // Random point and frame traffic with random content, plus noise words.
   task automatic test_random(int count);
      int r;
      logic [7:0] id;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 19);
         id = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
         if (r < 14)
            send_word(tct_pkg::OP_POINT, id, 2'($urandom_range(0, 3)), 1'($urandom),
                      16'($urandom), 16'($urandom), rand_xy_time(0, 30000));
         else if (r < 16)
            send_word(tct_pkg::OP_FRAME, 8'($urandom), 2'($urandom), 1'($urandom),
                      16'($urandom), 16'($urandom), rand_xy_time(0, 100));
         else if (r < 19)
            send_word(tct_pkg::OP_FRAME_SYN, 8'($urandom), 2'($urandom),
                      1'($urandom), 16'($urandom), 16'($urandom),
                      rand_xy_time(0, 100));
         else
            send_word(2'd3, 8'($urandom), 2'($urandom), 1'($urandom),
                      16'($urandom), 16'($urandom), {$urandom, 16'($urandom)});
      end
   endtask

   // Hold the receiver off while the sender keeps pushing presses.
   task automatic test_backpressure();
      hold_off = 400;
      random_gaps = 1'b0;
      for (int k = 0; k < 12; k++)
         send_word(tct_pkg::OP_POINT, 8'(k % tct_pkg::MAX_CONTACTS),
                   tct_pkg::PS_PRESSED, 1'b1,
                   16'($urandom), 16'($urandom), rand_xy_time(1, 50));
      random_gaps = 1'b1;
      drain();  // sender pauses until every event has come
   endtask

   initial begin
      req_ch.valid = 1'b0; req_ch.opcode = tct_pkg::OP_POINT; req_ch.contact_id = '0;
      req_ch.point_state = tct_pkg::PS_PRESSED; req_ch.active_flag = 1'b0;
      req_ch.pos_x = '0; req_ch.pos_y = '0; req_ch.stamp = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0; csr_ch.data = '0;
      tick_rate = tct_pkg::TPM_RESET;
      for (int i = 0; i < tct_pkg::MAX_CONTACTS; i++) begin
         live[i] = 1'b0; seen[i] = 1'b0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      write_rate(24'd0);
      test_directed();
      write_rate(24'hFFFFFF);
      test_random(15);
      write_rate(24'd1);
      test_random(25);
      test_backpressure();
      write_rate(24'd3000);
      test_random(40);
      write_rate(24'($urandom));
      test_random(20);

      drain();
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
